[rtl/core/smavg_pkg.sv]
// Shared types and constants of the six-channel moving-average filter.
package smavg_pkg;

   // Channel count and sample format.
   localparam int CHANNELS = 6;
   localparam int DATA_W   = 32;
   localparam int ROW_W    = CHANNELS * DATA_W;
   localparam int TOT_W    = DATA_W + $clog2(CHANNELS);

   // Window register.
   localparam int                WINDOW_W     = 9;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 9'd200;

   // One pose sample.
   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
      logic signed [DATA_W-1:0] roll_angle;
      logic signed [DATA_W-1:0] pitch_angle;
      logic signed [DATA_W-1:0] yaw_angle;
   } smavg_req_type;

   // One result: the latched means and whether the sample was taken.
   typedef struct packed {
      logic signed [DATA_W-1:0] mean_x;
      logic signed [DATA_W-1:0] mean_y;
      logic signed [DATA_W-1:0] mean_z;
      logic signed [DATA_W-1:0] mean_roll;
      logic signed [DATA_W-1:0] mean_pitch;
      logic signed [DATA_W-1:0] mean_yaw;
      logic                     sample_taken;
   } smavg_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic sum_check;
      logic shrink_start;
      logic shrink_issue;
      logic shrink_acc;
      logic wrap_step;
      logic ring_read;
      logic ring_update;
      logic div_load;
      logic div_step;
      logic out_load;
   } smavg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic nonzero;
      logic shrink_needed;
      logic shrink_last;
      logic wrap_needed;
      logic div_done;
   } smavg_status_type;

endpackage

[rtl/core/smavg_ifs.sv]
// Valid/ready stream interfaces for the sample and result channels.
interface smavg_req_if;
   logic                    valid;
   logic                    ready;
   smavg_pkg::smavg_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface smavg_rsp_if;
   logic                    valid;
   logic                    ready;
   smavg_pkg::smavg_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/smavg_div.sv]
// One lane of the serial divider: signed running sum over unsigned sample count.
module smavg_div #(
   parameter int SUM_W = 40,
   parameter int CNT_W = 9
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic                                step,
   input  logic signed [SUM_W-1:0]             dividend,
   input  logic        [CNT_W-1:0]             divisor,
   output logic signed [smavg_pkg::DATA_W-1:0] quotient
);

   logic             neg_ff;
   logic [SUM_W-1:0] work_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [SUM_W-1:0] mag;
   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   diff;
   logic             fits;
   logic [SUM_W-1:0] signed_quo;

   // Magnitude of the dividend; the sign is applied again at the end.
   assign mag = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;

   // Restoring step: one quotient bit per cycle, shifted in at the bottom.
   assign trial = {rem_ff, work_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = (trial >= {1'b0, divisor});

   always_ff @(posedge clock) begin
      if (load) begin
         neg_ff  <= dividend[SUM_W-1];
         work_ff <= mag;
         rem_ff  <= '0;
      end else if (step) begin
         work_ff <= {work_ff[SUM_W-2:0], fits};
         rem_ff  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      end
   end

   // Truncation toward zero, then the low word as the result.
   assign signed_quo = neg_ff ? (~work_ff + SUM_W'(1)) : work_ff;
   assign quotient   = signed_quo[smavg_pkg::DATA_W-1:0];

endmodule

[rtl/core/smavg_dp.sv]
// Datapath: window register, sample ring, running sums, divider lanes and result register.
module smavg_dp #(
   parameter int MAX_WINDOW = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [smavg_pkg::WINDOW_W-1:0]       csr_wr_data,
   input  smavg_pkg::smavg_req_type             req_payload,
   output smavg_pkg::smavg_rsp_type             rsp_payload,
   input  smavg_pkg::smavg_cmd_type             cmd,
   output smavg_pkg::smavg_status_type          status
);

   localparam int DATA_W   = smavg_pkg::DATA_W;
   localparam int CHANNELS = smavg_pkg::CHANNELS;
   localparam int IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W    = DATA_W + $clog2(MAX_WINDOW);
   localparam int EXT_W    = (CNT_W > smavg_pkg::WINDOW_W) ? CNT_W : smavg_pkg::WINDOW_W;
   localparam int STEP_W   = $clog2(SUM_W);

   logic [smavg_pkg::WINDOW_W-1:0] window_size_ff;
   logic signed [DATA_W-1:0]       req_vals [CHANNELS];
   logic signed [DATA_W-1:0]       vals_ff [CHANNELS];
   logic signed [DATA_W-1:0]       rd_vals [CHANNELS];
   logic signed [DATA_W-1:0]       quo [CHANNELS];
   logic signed [DATA_W-1:0]       means_sel [CHANNELS];
   logic signed [DATA_W-1:0]       latched_ff [CHANNELS];
   logic signed [SUM_W-1:0]        sum_ff [CHANNELS];
   logic signed [SUM_W-1:0]        old_val [CHANNELS];
   logic signed [smavg_pkg::TOT_W-1:0] total;
   logic                           nonzero_ff;
   logic [EXT_W-1:0]               ws_ext;
   logic [EXT_W-1:0]               win_ext;
   logic [CNT_W-1:0]               win_in;
   logic [CNT_W-1:0]               win_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [IDX_W-1:0]               wi_ff;
   logic [CNT_W-1:0]               wi_inc;
   logic [CNT_W-1:0]               wi_sub;
   logic [IDX_W-1:0]               scan_ff;
   logic                           fill_in;
   logic                           fill_ff;
   logic [IDX_W-1:0]               pos_in;
   logic [IDX_W-1:0]               pos_ff;
   logic [IDX_W-1:0]               rd_addr;
   logic                           rd_en;
   logic [smavg_pkg::ROW_W-1:0]    wr_row;
   logic [smavg_pkg::ROW_W-1:0]    rd_row_ff;
   logic [smavg_pkg::ROW_W-1:0]    ring_mem [MAX_WINDOW];
   logic [STEP_W-1:0]              step_ff;
   smavg_pkg::smavg_rsp_type       rsp_ff;

   // Window register, written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= smavg_pkg::WINDOW_RESET;
      end else if (csr_wr_en) begin
         window_size_ff <= csr_wr_data;
      end
   end

   // Clamp the window to the range the ring can hold.
   always_comb begin
      ws_ext = EXT_W'(window_size_ff);
      priority if (ws_ext == '0) begin
         win_ext = EXT_W'(1);
      end else if (ws_ext > EXT_W'(MAX_WINDOW)) begin
         win_ext = EXT_W'(MAX_WINDOW);
      end else begin
         win_ext = ws_ext;
      end
      win_in = win_ext[CNT_W-1:0];
   end

   // Channel order of the sample fields.
   assign req_vals[0] = req_payload.pos_x;
   assign req_vals[1] = req_payload.pos_y;
   assign req_vals[2] = req_payload.pos_z;
   assign req_vals[3] = req_payload.roll_angle;
   assign req_vals[4] = req_payload.pitch_angle;
   assign req_vals[5] = req_payload.yaw_angle;

   // Sample and window capture on an input transfer.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         vals_ff <= req_vals;
         win_ff  <= win_in;
      end
   end

   // A sample whose six channels sum to zero is rejected.
   always_comb begin
      total = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         total = total + smavg_pkg::TOT_W'(vals_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonzero_ff <= 1'b0;
      end else if (cmd.sum_check) begin
         nonzero_ff <= (total != '0);
      end
   end

   // Ring position: append while filling, overwrite the oldest once full.
   assign fill_in = (count_ff < win_ff);
   assign pos_in  = fill_in ? count_ff[IDX_W-1:0] : wi_ff;
   assign rd_addr = cmd.shrink_issue ? scan_ff : pos_in;
   assign rd_en   = cmd.shrink_issue | cmd.ring_read;

   always_ff @(posedge clock) begin
      if (cmd.ring_read) begin
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
      end
   end

   // Sample ring: one row holds all channels of one sample.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         wr_row[c*DATA_W +: DATA_W] = vals_ff[c];
         rd_vals[c] = signed'(rd_row_ff[c*DATA_W +: DATA_W]);
         old_val[c] = fill_ff ? '0 : SUM_W'(rd_vals[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ring_update) begin
         ring_mem[pos_ff] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= ring_mem[rd_addr];
      end
   end

   // Write index arithmetic.
   assign wi_inc = CNT_W'(wi_ff) + CNT_W'(1);
   assign wi_sub = CNT_W'(wi_ff) - win_ff;

   // Count, write index and shrink scan address.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wi_ff    <= '0;
         scan_ff  <= '0;
      end else begin
         if (cmd.shrink_start) begin
            count_ff <= win_ff;
            scan_ff  <= '0;
         end else if (cmd.shrink_issue) begin
            scan_ff <= scan_ff + IDX_W'(1);
         end
         if (cmd.wrap_step) begin
            wi_ff <= wi_sub[IDX_W-1:0];
         end else if (cmd.ring_update) begin
            wi_ff <= (wi_inc == win_ff) ? '0 : wi_inc[IDX_W-1:0];
            if (fill_ff) begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
      end
   end

   // Running sums: rebuilt by a scan on a shrink, and updated by every taken sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c] <= '0;
         end
      end else if (cmd.shrink_start) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c] <= '0;
         end
      end else if (cmd.shrink_acc) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c] <= sum_ff[c] + SUM_W'(rd_vals[c]);
         end
      end else if (cmd.ring_update) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c] <= sum_ff[c] + SUM_W'(vals_ff[c]) - old_val[c];
         end
      end
   end

   // Divider lanes share one step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.div_load) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      smavg_div #(
         .SUM_W (SUM_W),
         .CNT_W (CNT_W)
      ) u_div (
         .clock    (clock),
         .load     (cmd.div_load),
         .step     (cmd.div_step),
         .dividend (sum_ff[g]),
         .divisor  (count_ff),
         .quotient (quo[g])
      );
   end

   // Latched means: new quotients for a taken sample, the old means otherwise.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         means_sel[c] = nonzero_ff ? quo[c] : latched_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            latched_ff[c] <= '0;
         end
      end else if (cmd.out_load) begin
         latched_ff <= means_sel;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.mean_x       <= means_sel[0];
         rsp_ff.mean_y       <= means_sel[1];
         rsp_ff.mean_z       <= means_sel[2];
         rsp_ff.mean_roll    <= means_sel[3];
         rsp_ff.mean_pitch   <= means_sel[4];
         rsp_ff.mean_yaw     <= means_sel[5];
         rsp_ff.sample_taken <= nonzero_ff;
      end
   end

   assign rsp_payload = rsp_ff;

   // Status toward the controller.
   assign status.nonzero       = nonzero_ff;
   assign status.shrink_needed = (count_ff > win_ff);
   assign status.shrink_last   = (CNT_W'(scan_ff) == (win_ff - CNT_W'(1)));
   assign status.wrap_needed   = (CNT_W'(wi_ff) >= win_ff);
   assign status.div_done      = (step_ff == STEP_W'(SUM_W - 1));

endmodule

[rtl/core/smavg_ctrl.sv]
// Controller: sequences one sample at a time through the datapath and owns the handshakes.
module smavg_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output smavg_pkg::smavg_cmd_type    cmd,
   input  smavg_pkg::smavg_status_type status
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SUM    = 4'd1;
   localparam logic [3:0] ST_CHECK  = 4'd2;
   localparam logic [3:0] ST_SHRINK = 4'd3;
   localparam logic [3:0] ST_TAIL   = 4'd4;
   localparam logic [3:0] ST_WRAP   = 4'd5;
   localparam logic [3:0] ST_READ   = 4'd6;
   localparam logic [3:0] ST_UPDATE = 4'd7;
   localparam logic [3:0] ST_LOAD   = 4'd8;
   localparam logic [3:0] ST_DIV    = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       acc_pend_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_check = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (!status.nonzero) begin
               state_in = ST_OUT;
            end else if (status.shrink_needed) begin
               cmd.shrink_start = 1'b1;
               state_in         = ST_SHRINK;
            end else begin
               state_in = ST_WRAP;
            end
         end
         ST_SHRINK: begin
            cmd.shrink_issue = 1'b1;
            cmd.shrink_acc   = acc_pend_ff;
            if (status.shrink_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            cmd.shrink_acc = 1'b1;
            state_in       = ST_WRAP;
         end
         ST_WRAP: begin
            if (status.wrap_needed) begin
               cmd.wrap_step = 1'b1;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.ring_read = 1'b1;
            state_in      = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.ring_update = 1'b1;
            state_in        = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result register holds until its transfer.
   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_pend_ff  <= cmd.shrink_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/six_channel_moving_average.sv]
// Six-channel moving-average filter for pose samples: top level.
// A taken sample passes the sum check, an optional ring rescan on a window shrink, index wrap
// steps, ring read and update and the bit-serial divider lanes; a rejected sample goes from
// the check straight to the result register.
// A new sample is taken only after the last one is through; the next one is taken while a result waits.
// Reset (synchronous): sums, count, index and means clear, the window returns to 200.
module six_channel_moving_average #(
   parameter int MAX_WINDOW = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   smavg_req_if.sink                      req_chan,
   smavg_rsp_if.source                    rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [smavg_pkg::WINDOW_W-1:0] csr_wr_data
);

   smavg_pkg::smavg_cmd_type    cmd;
   smavg_pkg::smavg_status_type status;

   // Sequencer.
   smavg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Ring, sums and dividers.
   smavg_dp #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_chan.payload),
      .rsp_payload (rsp_chan.payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

[rtl/core/smavg_checker.sv]
// Port-level checks of the moving-average filter and their binding to the top level.
module smavg_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input smavg_pkg::smavg_rsp_type rsp_payload
);

   logic                                   req_xfer;
   logic                                   rsp_xfer;
   logic [1:0]                             pend_ff;
   logic [1:0]                             pend_in;
   logic signed [smavg_pkg::DATA_W-1:0]    last_x_ff;
   logic signed [smavg_pkg::DATA_W-1:0]    last_y_ff;
   logic signed [smavg_pkg::DATA_W-1:0]    last_z_ff;
   logic signed [smavg_pkg::DATA_W-1:0]    last_roll_ff;
   logic signed [smavg_pkg::DATA_W-1:0]    last_pitch_ff;
   logic signed [smavg_pkg::DATA_W-1:0]    last_yaw_ff;

   assign req_xfer = req_valid & req_ready;
   assign rsp_xfer = rsp_valid & rsp_ready;
   assign pend_in  = pend_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};

   // Samples taken but not yet answered, and the means of the last result transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= '0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         last_z_ff     <= '0;
         last_roll_ff  <= '0;
         last_pitch_ff <= '0;
         last_yaw_ff   <= '0;
      end else begin
         pend_ff <= pend_in;
         if (rsp_xfer) begin
            last_x_ff     <= rsp_payload.mean_x;
            last_y_ff     <= rsp_payload.mean_y;
            last_z_ff     <= rsp_payload.mean_z;
            last_roll_ff  <= rsp_payload.mean_roll;
            last_pitch_ff <= rsp_payload.mean_pitch;
            last_yaw_ff   <= rsp_payload.mean_yaw;
         end
      end
   end

   // A result waiting for its transfer holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed or dropped before its transfer");

   // One sample in work at a time: ready drops after every input transfer.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("input accepted twice in a row");

   // Every result belongs to a sample, and at most two are in flight.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a sample");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many samples in flight");

   // A rejected sample repeats the means last delivered.
   a_reject_repeats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.sample_taken |->
         rsp_payload.mean_x == last_x_ff && rsp_payload.mean_y == last_y_ff &&
         rsp_payload.mean_z == last_z_ff && rsp_payload.mean_roll == last_roll_ff &&
         rsp_payload.mean_pitch == last_pitch_ff && rsp_payload.mean_yaw == last_yaw_ff)
      else $error("rejected sample changed the means");

endmodule

bind six_channel_moving_average smavg_checker u_smavg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
